### design/rmd160_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmd160_pkg: shared types and constants for the RIPEMD-160 hash block
// Chain value layout, initial words and the control/status structs between
// the top level and the compression core.
// ----------------------------------------------------------------------------
package rmd160_pkg;

    localparam int CHAIN_WORDS = 5;

    typedef logic [CHAIN_WORDS-1:0][31:0] chain_t;

    localparam chain_t CHAIN_INIT = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_byte;
        logic       start;
        logic       reinit;
    } ctrl_t;

    typedef struct packed {
        logic busy;
    } status_t;

endpackage : rmd160_pkg
`default_nettype wire

### design/rmd160_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmd160_core: block buffer and iterative compression engine
// Holds the 64-byte block buffer and chain value; runs one left/right round
// pair per cycle for 80 rounds, then folds into the chain value.
// ----------------------------------------------------------------------------
module rmd160_core (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire rmd160_pkg::ctrl_t ctrl,
    output rmd160_pkg::status_t  status,
    output rmd160_pkg::chain_t   chain_o
);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_FOLD} cstate_t;

    localparam logic [6:0] LAST_ROUND = 7'd79;

    localparam logic [3:0] SEL_L [80] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
        4'd7, 4'd4, 4'd13, 4'd1, 4'd10, 4'd6, 4'd15, 4'd3,
        4'd12, 4'd0, 4'd9, 4'd5, 4'd2, 4'd14, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd14, 4'd4, 4'd9, 4'd15, 4'd8, 4'd1,
        4'd2, 4'd7, 4'd0, 4'd6, 4'd13, 4'd11, 4'd5, 4'd12,
        4'd1, 4'd9, 4'd11, 4'd10, 4'd0, 4'd8, 4'd12, 4'd4,
        4'd13, 4'd3, 4'd7, 4'd15, 4'd14, 4'd5, 4'd6, 4'd2,
        4'd4, 4'd0, 4'd5, 4'd9, 4'd7, 4'd12, 4'd2, 4'd10,
        4'd14, 4'd1, 4'd3, 4'd8, 4'd11, 4'd6, 4'd15, 4'd13
    };

    localparam logic [3:0] SEL_R [80] = '{
        4'd5, 4'd14, 4'd7, 4'd0, 4'd9, 4'd2, 4'd11, 4'd4,
        4'd13, 4'd6, 4'd15, 4'd8, 4'd1, 4'd10, 4'd3, 4'd12,
        4'd6, 4'd11, 4'd3, 4'd7, 4'd0, 4'd13, 4'd5, 4'd10,
        4'd14, 4'd15, 4'd8, 4'd12, 4'd4, 4'd9, 4'd1, 4'd2,
        4'd15, 4'd5, 4'd1, 4'd3, 4'd7, 4'd14, 4'd6, 4'd9,
        4'd11, 4'd8, 4'd12, 4'd2, 4'd10, 4'd0, 4'd4, 4'd13,
        4'd8, 4'd6, 4'd4, 4'd1, 4'd3, 4'd11, 4'd15, 4'd0,
        4'd5, 4'd12, 4'd2, 4'd13, 4'd9, 4'd7, 4'd10, 4'd14,
        4'd12, 4'd15, 4'd10, 4'd4, 4'd1, 4'd5, 4'd8, 4'd7,
        4'd6, 4'd2, 4'd13, 4'd14, 4'd0, 4'd3, 4'd9, 4'd11
    };

    localparam logic [3:0] ROT_L [80] = '{
        4'd11, 4'd14, 4'd15, 4'd12, 4'd5, 4'd8, 4'd7, 4'd9,
        4'd11, 4'd13, 4'd14, 4'd15, 4'd6, 4'd7, 4'd9, 4'd8,
        4'd7, 4'd6, 4'd8, 4'd13, 4'd11, 4'd9, 4'd7, 4'd15,
        4'd7, 4'd12, 4'd15, 4'd9, 4'd11, 4'd7, 4'd13, 4'd12,
        4'd11, 4'd13, 4'd6, 4'd7, 4'd14, 4'd9, 4'd13, 4'd15,
        4'd14, 4'd8, 4'd13, 4'd6, 4'd5, 4'd12, 4'd7, 4'd5,
        4'd11, 4'd12, 4'd14, 4'd15, 4'd14, 4'd15, 4'd9, 4'd8,
        4'd9, 4'd14, 4'd5, 4'd6, 4'd8, 4'd6, 4'd5, 4'd12,
        4'd9, 4'd15, 4'd5, 4'd11, 4'd6, 4'd8, 4'd13, 4'd12,
        4'd5, 4'd12, 4'd13, 4'd14, 4'd11, 4'd8, 4'd5, 4'd6
    };

    localparam logic [3:0] ROT_R [80] = '{
        4'd8, 4'd9, 4'd9, 4'd11, 4'd13, 4'd15, 4'd15, 4'd5,
        4'd7, 4'd7, 4'd8, 4'd11, 4'd14, 4'd14, 4'd12, 4'd6,
        4'd9, 4'd13, 4'd15, 4'd7, 4'd12, 4'd8, 4'd9, 4'd11,
        4'd7, 4'd7, 4'd12, 4'd7, 4'd6, 4'd15, 4'd13, 4'd11,
        4'd9, 4'd7, 4'd15, 4'd11, 4'd8, 4'd6, 4'd6, 4'd14,
        4'd12, 4'd13, 4'd5, 4'd14, 4'd13, 4'd13, 4'd7, 4'd5,
        4'd15, 4'd5, 4'd8, 4'd11, 4'd14, 4'd14, 4'd6, 4'd14,
        4'd6, 4'd9, 4'd12, 4'd9, 4'd12, 4'd5, 4'd15, 4'd8,
        4'd8, 4'd5, 4'd12, 4'd9, 4'd12, 4'd5, 4'd14, 4'd6,
        4'd8, 4'd13, 4'd6, 4'd5, 4'd15, 4'd13, 4'd11, 4'd11
    };

    localparam logic [31:0] K_L [5] = '{
        32'h00000000, 32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'ha953fd4e
    };

    localparam logic [31:0] K_R [5] = '{
        32'h50a28be6, 32'h5c4dd124, 32'h6d703ef3, 32'h7a6d76e9, 32'h00000000
    };

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [3:0] n);
        logic [63:0] t;
        t = {v, v} << n;
        return t[63:32];
    endfunction

    function automatic logic [31:0] mix(input logic [2:0] grp, input logic [31:0] x,
                                        input logic [31:0] y, input logic [31:0] z);
        case (grp)
            3'd0: return x ^ y ^ z;
            3'd1: return (x & y) | (~x & z);
            3'd2: return (x | ~y) ^ z;
            3'd3: return (x & z) | (y & ~z);
            default: return x ^ (y | ~z);
        endcase
    endfunction

    cstate_t             cstate_reg;
    logic [6:0]          round_reg;
    rmd160_pkg::chain_t  chain_reg;
    logic [31:0]         a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]         ap_reg, bp_reg, cp_reg, dp_reg, ep_reg;
    logic [31:0]         wl_reg, wr_reg;
    logic [31:0]         buf_mem [16];

    logic [6:0]          rd_idx;
    logic [2:0]          grp;
    logic [31:0]         t_l, t_r;

    // read address runs one round ahead of the data
    always_comb begin
        if (cstate_reg == C_RUN && round_reg != LAST_ROUND) begin
            rd_idx = round_reg + 7'd1;
        end else begin
            rd_idx = 7'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            buf_mem[ctrl.wr_addr[5:2]][{ctrl.wr_addr[1:0], 3'b000} +: 8] <= ctrl.wr_byte;
        end
        wl_reg <= buf_mem[SEL_L[rd_idx]];
        wr_reg <= buf_mem[SEL_R[rd_idx]];
    end

    assign grp = round_reg[6:4];
    assign t_l = rotl32(a_reg + mix(grp, b_reg, c_reg, d_reg) + wl_reg + K_L[grp],
                        ROT_L[round_reg]) + e_reg;
    assign t_r = rotl32(ap_reg + mix(3'd4 - grp, bp_reg, cp_reg, dp_reg) + wr_reg + K_R[grp],
                        ROT_R[round_reg]) + ep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cstate_reg <= C_IDLE;
            round_reg  <= 7'd0;
            chain_reg  <= rmd160_pkg::CHAIN_INIT;
        end else begin
            case (cstate_reg)
                C_IDLE: begin
                    if (ctrl.reinit) begin
                        chain_reg <= rmd160_pkg::CHAIN_INIT;
                    end
                    if (ctrl.start) begin
                        a_reg      <= chain_reg[0];
                        b_reg      <= chain_reg[1];
                        c_reg      <= chain_reg[2];
                        d_reg      <= chain_reg[3];
                        e_reg      <= chain_reg[4];
                        ap_reg     <= chain_reg[0];
                        bp_reg     <= chain_reg[1];
                        cp_reg     <= chain_reg[2];
                        dp_reg     <= chain_reg[3];
                        ep_reg     <= chain_reg[4];
                        round_reg  <= 7'd0;
                        cstate_reg <= C_RUN;
                    end
                end
                C_RUN: begin
                    a_reg  <= e_reg;
                    e_reg  <= d_reg;
                    d_reg  <= rotl32(c_reg, 4'd10);
                    c_reg  <= b_reg;
                    b_reg  <= t_l;
                    ap_reg <= ep_reg;
                    ep_reg <= dp_reg;
                    dp_reg <= rotl32(cp_reg, 4'd10);
                    cp_reg <= bp_reg;
                    bp_reg <= t_r;
                    if (round_reg == LAST_ROUND) begin
                        cstate_reg <= C_FOLD;
                    end else begin
                        round_reg <= round_reg + 7'd1;
                    end
                end
                C_FOLD: begin
                    chain_reg[0] <= chain_reg[1] + c_reg + dp_reg;
                    chain_reg[1] <= chain_reg[2] + d_reg + ep_reg;
                    chain_reg[2] <= chain_reg[3] + e_reg + ap_reg;
                    chain_reg[3] <= chain_reg[4] + a_reg + bp_reg;
                    chain_reg[4] <= chain_reg[0] + b_reg + cp_reg;
                    cstate_reg   <= C_IDLE;
                end
                default: begin
                    cstate_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign status.busy = (cstate_reg != C_IDLE);
    assign chain_o     = chain_reg;

endmodule : rmd160_core
`default_nettype wire

### design/ripemd160_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ripemd160_hash: RIPEMD-160 digest of a byte stream
// Byte intake, message padding, length append and digest output around an
// iterative compression core.
// ----------------------------------------------------------------------------
// A data word (s_tuser = 0) is accepted while s_tready is high. After the 64th
// byte of a block, the block is compressed and s_tready stays low until done:
// the core runs one left/right round pair per cycle for 80 rounds, then a fold
// step. A finish word (s_tuser = 1) pads the block one byte per cycle (9 to
// 72 bytes), compresses once or twice, then presents five digest words on the
// m_ side, word 0 first, m_tlast on word 4. The block buffer is a 16 x 32-bit
// memory with two read ports; its contents need no clearing after reset.
module ripemd160_hash (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire  [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);

    typedef enum logic [2:0] {S_IDLE, S_PAD, S_START, S_WAIT, S_OUT} state_t;

    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd4;

    state_t      state_reg;
    logic [5:0]  fill_reg;
    logic [63:0] bitlen_reg;
    logic [63:0] len_reg;
    logic        first_reg;
    logic        len_phase_reg;
    logic        fin_reg;
    logic [2:0]  out_idx_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;
    logic        m_tlast_reg;

    rmd160_pkg::ctrl_t   core_ctrl;
    rmd160_pkg::status_t core_st;
    rmd160_pkg::chain_t  chain;

    logic        s_accept;
    logic        out_load;
    logic [7:0]  pad_byte;
    logic [31:0] sel_word;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign sel_word = chain[out_idx_reg];

    always_comb begin
        if (first_reg) begin
            pad_byte = 8'h80;
        end else if (len_phase_reg || fill_reg == LEN_OFFSET) begin
            pad_byte = len_reg[{fill_reg[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        core_ctrl.wr_addr = fill_reg;
        core_ctrl.start   = (state_reg == S_START);
        core_ctrl.reinit  = out_load && (out_idx_reg == LAST_WORD);
        if (state_reg == S_PAD) begin
            core_ctrl.wr_en   = 1'b1;
            core_ctrl.wr_byte = pad_byte;
        end else begin
            core_ctrl.wr_en   = s_accept && !s_tuser[0];
            core_ctrl.wr_byte = s_tdata;
        end
    end

    rmd160_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (core_ctrl),
        .status  (core_st),
        .chain_o (chain)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= 6'd0;
            bitlen_reg    <= 64'd0;
            first_reg     <= 1'b0;
            len_phase_reg <= 1'b0;
            fin_reg       <= 1'b0;
            out_idx_reg   <= 3'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        if (!s_tuser[0]) begin
                            fill_reg   <= fill_reg + 6'd1;
                            bitlen_reg <= bitlen_reg + 64'd8;
                            fin_reg    <= 1'b0;
                            if (fill_reg == LAST_BYTE) begin
                                state_reg <= S_START;
                            end
                        end else begin
                            len_reg       <= bitlen_reg;
                            first_reg     <= 1'b1;
                            len_phase_reg <= 1'b0;
                            fin_reg       <= 1'b1;
                            state_reg     <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    fill_reg  <= fill_reg + 6'd1;
                    first_reg <= 1'b0;
                    if (!first_reg && fill_reg == LEN_OFFSET) begin
                        len_phase_reg <= 1'b1;
                    end
                    if (fill_reg == LAST_BYTE) begin
                        state_reg <= S_START;
                    end
                end
                S_START: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (!core_st.busy) begin
                        if (!fin_reg) begin
                            state_reg <= S_IDLE;
                        end else if (len_phase_reg) begin
                            out_idx_reg <= 3'd0;
                            state_reg   <= S_OUT;
                        end else begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {sel_word[7:0], sel_word[15:8],
                                         sel_word[23:16], sel_word[31:24]};
                        m_tuser_reg  <= out_idx_reg;
                        m_tlast_reg  <= (out_idx_reg == LAST_WORD);
                        if (out_idx_reg == LAST_WORD) begin
                            bitlen_reg    <= 64'd0;
                            fin_reg       <= 1'b0;
                            len_phase_reg <= 1'b0;
                            state_reg     <= S_IDLE;
                        end else begin
                            out_idx_reg <= out_idx_reg + 3'd1;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_no_intake_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        core_st.busy |-> !s_tready)
        else $error("input taken while compression running");

    a_last_on_word4: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == LAST_WORD)))
        else $error("tlast not aligned with final digest word");

    a_block_done_on_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |-> (fill_reg == 6'd0 && !core_st.busy))
        else $error("digest output with partial block");

    a_start_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        core_ctrl.start |=> core_st.busy)
        else $error("core did not start");

endmodule : ripemd160_hash
`default_nettype wire
